/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: invariant");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/qmst_pkg.sv */
// ----------------------------------------------------------------------------
// qmst_pkg
// Types and constants shared by the quality segment trimmer.
// ----------------------------------------------------------------------------
package qmst_pkg;

    localparam int QUAL_W     = 8;
    localparam int OFFSET_W   = 7;
    localparam int CUTOFF_W   = 7;
    localparam int MINLEN_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_QUALITY_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHRED_CUTOFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINIMUM_LENGTH = 2'd2;

    // common ASCII encodings of phred quality
    localparam logic [OFFSET_W-1:0] ILLUMINA_OFFSET = 7'd64;
    localparam logic [OFFSET_W-1:0] SANGER_OFFSET   = 7'd33;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = ILLUMINA_OFFSET;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 7'd20;
    localparam logic [MINLEN_W-1:0] MINLEN_RESET = 13'd30;

    typedef enum logic [1:0] {
        SCORE_ZERO = 2'd0,
        SCORE_POS  = 2'd1,
        SCORE_NEG  = 2'd2
    } t_score;

    // one scored base
    typedef struct packed {
        t_score score;
        logic   last;
    } t_item;

    // live configuration
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [CUTOFF_W-1:0] cutoff;
        logic [MINLEN_W-1:0] min_len;
    } t_cfg;

endpackage

/* rtl/qmst_score.sv */
// ----------------------------------------------------------------------------
// qmst_score
// Maps a raw quality byte to +1 / 0 / -1 against offset plus cutoff.
// ----------------------------------------------------------------------------
module qmst_score (
    input  logic [qmst_pkg::QUAL_W-1:0] i_quality_char,
    input  logic                        i_last_base,
    input  qmst_pkg::t_cfg              i_cfg,
    output qmst_pkg::t_item             o_item
);
    import qmst_pkg::*;

    logic [QUAL_W-1:0] thresh;

    // offset + cutoff is at most 254, fits the byte width
    assign thresh = QUAL_W'({1'b0, i_cfg.offset}) + QUAL_W'({1'b0, i_cfg.cutoff});

    always_comb begin
        o_item.last = i_last_base;
        if (i_quality_char > thresh) begin
            o_item.score = SCORE_POS;
        end else if (i_quality_char < thresh) begin
            o_item.score = SCORE_NEG;
        end else begin
            o_item.score = SCORE_ZERO;
        end
    end

endmodule

/* rtl/qmst_kadane.sv */
// ----------------------------------------------------------------------------
// qmst_kadane
// Max-sum segment state update and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qmst_kadane #(
    parameter int MAX_READ_LEN = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  qmst_pkg::t_cfg                          i_cfg,
    input  logic                                    i_valid,
    input  qmst_pkg::t_item                         i_item,
    output logic                                    o_ready,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [$clog2(MAX_READ_LEN)-1:0]         o_trim_start,
    output logic [$clog2(MAX_READ_LEN)-1:0]         o_trim_end,
    output logic [$clog2(MAX_READ_LEN+1)-1:0]       o_best_sum,
    output logic                                    o_keep_read
);
    import qmst_pkg::*;

    localparam int IW = $clog2(MAX_READ_LEN);
    localparam int SW = $clog2(MAX_READ_LEN + 1);
    localparam int LW = (IW + 1 > MINLEN_W) ? IW + 1 : MINLEN_W;
    localparam logic [IW-1:0] IDX_MAX = IW'(MAX_READ_LEN - 1);
    localparam logic [SW-1:0] SUM_MAX = SW'(MAX_READ_LEN);

    logic [IW-1:0] r_base_index;
    logic [SW-1:0] r_running_sum;
    logic [SW-1:0] r_best_score;
    logic [IW-1:0] r_cand_start;
    logic [IW-1:0] r_best_start;
    logic [IW-1:0] r_best_end;

    logic          r_out_valid;
    logic [IW-1:0] r_trim_start;
    logic [IW-1:0] r_trim_end;
    logic [SW-1:0] r_best_sum;
    logic          r_keep_read;

    logic [IW-1:0] idx_inc;
    logic [SW-1:0] n_running_sum;
    logic [SW-1:0] n_best_score;
    logic [IW-1:0] n_cand_start;
    logic [IW-1:0] n_best_start;
    logic [IW-1:0] n_best_end;
    logic          went_neg;
    logic [IW:0]   span;
    logic [IW:0]   seg_len;
    logic [IW-1:0] n_trim_start;
    logic [IW-1:0] n_trim_end;
    logic [SW-1:0] n_best_sum;
    logic          n_keep_read;
    logic          step;

    // a last base needs room in the result register
    assign o_ready = !i_item.last || !r_out_valid || i_out_ready;
    assign step    = i_valid && o_ready;

    assign idx_inc = (r_base_index < IDX_MAX) ? r_base_index + 1'b1 : IDX_MAX;

    always_comb begin
        n_running_sum = r_running_sum;
        went_neg      = 1'b0;
        unique case (i_item.score)
            SCORE_POS: begin
                if (r_running_sum != SUM_MAX) begin
                    n_running_sum = r_running_sum + 1'b1;
                end
            end
            SCORE_NEG: begin
                if (r_running_sum == '0) begin
                    went_neg = 1'b1;
                end else begin
                    n_running_sum = r_running_sum - 1'b1;
                end
            end
            default: begin
            end
        endcase

        n_best_score = r_best_score;
        n_best_start = r_best_start;
        n_best_end   = r_best_end;
        n_cand_start = r_cand_start;
        if (n_running_sum > r_best_score) begin
            n_best_score = n_running_sum;
            n_best_start = r_cand_start;
            n_best_end   = r_base_index;
        end else if (went_neg) begin
            n_cand_start = idx_inc;
        end

        span    = {1'b0, n_best_end} - {1'b0, n_best_start} + 1'b1;
        seg_len = (n_best_end >= n_best_start) ? span : (IW+1)'(1);

        // zero cutoff: keep the whole read
        if (i_cfg.cutoff == '0) begin
            n_trim_start = '0;
            n_trim_end   = r_base_index;
            n_best_sum   = '0;
            n_keep_read  = 1'b1;
        end else begin
            n_trim_start = n_best_start;
            n_trim_end   = n_best_end;
            n_best_sum   = n_best_score;
            n_keep_read  = LW'(seg_len) >= LW'(i_cfg.min_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_index  <= '0;
            r_running_sum <= '0;
            r_best_score  <= '0;
            r_cand_start  <= '0;
            r_best_start  <= '0;
            r_best_end    <= '0;
        end else if (step) begin
            if (i_item.last) begin
                r_base_index  <= '0;
                r_running_sum <= '0;
                r_best_score  <= '0;
                r_cand_start  <= '0;
                r_best_start  <= '0;
                r_best_end    <= '0;
            end else begin
                r_base_index  <= idx_inc;
                r_running_sum <= n_running_sum;
                r_best_score  <= n_best_score;
                r_cand_start  <= n_cand_start;
                r_best_start  <= n_best_start;
                r_best_end    <= n_best_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && i_item.last) begin
            r_trim_start <= n_trim_start;
            r_trim_end   <= n_trim_end;
            r_best_sum   <= n_best_sum;
            r_keep_read  <= n_keep_read;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_trim_start = r_trim_start;
    assign o_trim_end   = r_trim_end;
    assign o_best_sum   = r_best_sum;
    assign o_keep_read  = r_keep_read;

    `ASSERT_ALWAYS(a_sum_bounded, i_clk, i_rst_n, r_running_sum <= SUM_MAX)
    `ASSERT_ALWAYS(a_best_covers_sum, i_clk, i_rst_n, r_best_score >= r_running_sum)
    `ASSERT_ALWAYS(a_best_ordered, i_clk, i_rst_n, r_best_start <= r_best_end)
    `ASSERT_ALWAYS(a_cand_behind, i_clk, i_rst_n, r_cand_start <= r_base_index)
    `ASSERT_NEXT(a_clear_after_read, i_clk, i_rst_n, step && i_item.last, r_base_index == '0 && r_best_score == '0 && r_out_valid)

endmodule

/* rtl/quality_max_segment_trimmer.sv */
// ----------------------------------------------------------------------------
// quality_max_segment_trimmer
// Streams one quality byte per base and reports the maximum-score segment of
// each read on its last base.
//
// Each accepted request carries one quality byte and a last-base flag. The
// byte is scored +1, 0 or -1 against the encoding offset plus the phred cutoff
// when it is taken into the input register; when the core takes it from there,
// the running-sum search updates its state and, on a last base, loads the
// result register with the best segment bounds (inclusive), its score and the
// keep flag, then clears for the next read. Throughput is one base per cycle
// while the input does not stall: the running-sum update is the only loop, and
// the input register accepts a new base while a result still waits in the
// output register. o_out_valid rises once the last base has passed the input
// register and then loaded the result register; a stall can hold it in the
// input register between the two. The input side stalls only when a last base
// meets a full result register that is not being drained.
// A cutoff of zero keeps the whole read (start 0, end at the last index, sum
// 0). Bases past MAX_READ_LEN-1 are scored at the saturated index. The config
// port is always ready. The user must let a write land mid-read only while no
// base is waiting in the input register; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module quality_max_segment_trimmer #(
    parameter int MAX_READ_LEN = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // base requests
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [qmst_pkg::QUAL_W-1:0]         i_quality_char,
    input  logic                                i_last_base,
    // trim results
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [$clog2(MAX_READ_LEN)-1:0]     o_trim_start,
    output logic [$clog2(MAX_READ_LEN)-1:0]     o_trim_end,
    output logic [$clog2(MAX_READ_LEN+1)-1:0]   o_best_sum,
    output logic                                o_keep_read,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qmst_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [qmst_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import qmst_pkg::*;

    t_cfg  r_cfg;
    logic  r_in_valid;
    t_item r_in_item;
    t_item scored;
    logic  core_ready;
    logic  in_take;

    // ---- configuration registers ----
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset  <= OFFSET_RESET;
            r_cfg.cutoff  <= CUTOFF_RESET;
            r_cfg.min_len <= MINLEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_QUALITY_OFFSET: r_cfg.offset  <= i_cfg_data[OFFSET_W-1:0];
                CFG_PHRED_CUTOFF:   r_cfg.cutoff  <= i_cfg_data[CUTOFF_W-1:0];
                CFG_MINIMUM_LENGTH: r_cfg.min_len <= i_cfg_data[MINLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---- scoring into the input register ----
    qmst_score u_score (
        .i_quality_char (i_quality_char),
        .i_last_base    (i_last_base),
        .i_cfg          (r_cfg),
        .o_item         (scored)
    );

    // input register frees up whenever the core takes its item
    assign o_in_ready = !r_in_valid || core_ready;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (core_ready) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= scored;
        end
    end

    // ---- segment search and result register ----
    qmst_kadane #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_kadane (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (r_in_valid),
        .i_item       (r_in_item),
        .o_ready      (core_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_trim_start (o_trim_start),
        .o_trim_end   (o_trim_end),
        .o_best_sum   (o_best_sum),
        .o_keep_read  (o_keep_read)
    );

endmodule

/* bench/tb_quality_max_segment_trimmer.sv */
// ----------------------------------------------------------------------------
// tb_quality_max_segment_trimmer
// Self-checking bench for the quality segment trimmer. Quality bytes are sent
// as requests over the valid/ready input channel. A bench-side running-sum
// search predicts the trim result of every read, and each result taken from
// the output channel is checked against the oldest prediction. A short
// directed table comes first. Random reads follow, under several register
// settings and with sender gaps and receiver stalls. The run ends with one
// long drain hold-off.
// ----------------------------------------------------------------------------
module tb_quality_max_segment_trimmer;

    import qmst_pkg::*;

    localparam int MAX_LEN        = 4096;
    localparam int IDX_CAP        = MAX_LEN - 1;
    localparam int SUM_CAP        = MAX_LEN;
    // a result passes the input and result registers; give it some margin
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 80;
    localparam int TIMEOUT_CYCLES = 400000;

    // one trim result, laid out as on the output ports
    typedef struct packed {
        logic [11:0] seg_first;
        logic [11:0] seg_last;
        logic [12:0] score;
        logic        keep;
    } t_trim;

    localparam t_trim NO_TRIM = '0;

    // directed table: either a base request or a register write
    typedef enum logic {
        ROW_BASE,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_sel;  // register, for ROW_CFG
        logic [12:0]          value;    // quality byte or register data
        logic                 last;
        logic                 typed;    // expected result typed in below
        t_trim                want;
    } t_row;

    localparam int DIR_ROWS = 29;

    // Default setting: threshold 84, minimum length 30.
    localparam t_row DIRECTED [DIR_ROWS] = '{
        // no positive segment: single low base
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd0,   1'b1, 1'b1,
          '{12'd0, 12'd0, 13'd0, 1'b0}},
        // top byte: one positive base, too short to keep
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd255, 1'b1, 1'b1,
          '{12'd0, 12'd0, 13'd1, 1'b0}},
        // byte right on the threshold scores zero
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd84,  1'b1, 1'b1,
          '{12'd0, 12'd0, 13'd0, 1'b0}},
        // up, up, down, up
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd85,  1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd86,  1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd83,  1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd200, 1'b1, 1'b0, NO_TRIM},
        // low head moves the candidate start
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd0,   1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd0,   1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd255, 1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd255, 1'b1, 1'b0, NO_TRIM},
        // minimum length 1: a single good base is kept
        '{ROW_CFG,  CFG_MINIMUM_LENGTH, 13'd1,   1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd255, 1'b1, 1'b1,
          '{12'd0, 12'd0, 13'd1, 1'b1}},
        // cutoff 0: trimming off, whole read kept
        '{ROW_CFG,  CFG_PHRED_CUTOFF,   13'd0,   1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd0,   1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd128, 1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd0,   1'b1, 1'b1,
          '{12'd0, 12'd2, 13'd0, 1'b1}},
        // both registers at the top: threshold 254
        '{ROW_CFG,  CFG_QUALITY_OFFSET, 13'd127,  1'b0, 1'b0, NO_TRIM},
        '{ROW_CFG,  CFG_PHRED_CUTOFF,   13'd127,  1'b0, 1'b0, NO_TRIM},
        '{ROW_CFG,  CFG_MINIMUM_LENGTH, 13'd4096, 1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd255, 1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd254, 1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd253, 1'b0, 1'b0, NO_TRIM},
        // offset changed in the middle of the read: threshold 127
        '{ROW_CFG,  CFG_QUALITY_OFFSET, 13'd0,   1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd127, 1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd128, 1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd130, 1'b1, 1'b0, NO_TRIM},
        // Sanger encoding, minimum length still 4096
        '{ROW_CFG,  CFG_QUALITY_OFFSET, 13'd33,  1'b0, 1'b0, NO_TRIM},
        '{ROW_BASE, CFG_QUALITY_OFFSET, 13'd60,  1'b1, 1'b0, NO_TRIM}
    };

    // random phases: register setting plus sender gap / receiver stall rates
    typedef struct packed {
        logic [6:0]  offset;
        logic [6:0]  cutoff;
        logic [12:0] min_len;
        logic [6:0]  idle_pct;
        logic [6:0]  stall_pct;
        logic [7:0]  bases;
    } t_phase;

    localparam int PHASES = 8;

    localparam t_phase PHASE_SET [PHASES] = '{
        '{7'd64,  7'd20,  13'd30,   7'd0,  7'd0,  8'd50},
        '{7'd33,  7'd20,  13'd5,    7'd72, 7'd0,  8'd48},
        '{7'd33,  7'd0,   13'd30,   7'd0,  7'd72, 8'd46},
        '{7'd0,   7'd0,   13'd0,    7'd18, 7'd18, 8'd42},
        '{7'd127, 7'd127, 13'd4096, 7'd72, 7'd0,  8'd38},
        '{7'd0,   7'd127, 13'd1,    7'd0,  7'd72, 8'd46},
        '{7'd64,  7'd10,  13'd12,   7'd18, 7'd18, 8'd54},
        '{7'd33,  7'd30,  13'd20,   7'd0,  7'd0,  8'd56}
    };

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [QUAL_W-1:0]     i_quality_char = '0;
    logic                  i_last_base    = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [11:0]           o_trim_start;
    logic [11:0]           o_trim_end;
    logic [12:0]           o_best_sum;
    logic                  o_keep_read;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_QUALITY_OFFSET;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // traffic shaping, set by the stimulus process (hold-off count: result side)
    int   send_idle_pct = 0;
    int   drain_stall_pct = 0;
    logic drain_hold_go = 1'b0;
    int   drain_hold_left = 0;

    // bench copy of the registers
    logic [OFFSET_W-1:0] cfg_offset  = OFFSET_RESET;
    logic [CUTOFF_W-1:0] cfg_cutoff  = CUTOFF_RESET;
    logic [MINLEN_W-1:0] cfg_min_len = MINLEN_RESET;

    // bench copy of the per-read search state
    logic [11:0] pos_idx    = '0;
    logic [12:0] run_sum    = '0;
    logic [12:0] best_total = '0;
    logic [11:0] seg_start  = '0;
    logic [11:0] best_lo    = '0;
    logic [11:0] best_hi    = '0;

    // random read shaping; a read may run across phase boundaries
    int read_len = 0;
    int read_pos = 0;
    int win_lo   = 0;
    int win_hi   = 0;

    t_trim expected_trims [$];
    int    mismatch_count = 0;

    quality_max_segment_trimmer #(
        .MAX_READ_LEN(MAX_LEN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_quality_char (i_quality_char),
        .i_last_base    (i_last_base),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_trim_start   (o_trim_start),
        .o_trim_end     (o_trim_end),
        .o_best_sum     (o_best_sum),
        .o_keep_read    (o_keep_read),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Score one base and advance the running-sum search. Returns 1 with the
    // trim result when the base closes a read.
    function automatic bit score_base(input logic [7:0] q, input logic last,
                                      output t_trim res);
        int     diff;
        int     sum;
        int     j;
        int     len;
        t_score sc;
        diff = int'(q) - int'(cfg_offset) - int'(cfg_cutoff);
        sc   = (diff > 0) ? SCORE_POS : ((diff < 0) ? SCORE_NEG : SCORE_ZERO);
        j    = int'(pos_idx);
        sum  = int'(run_sum);
        if (sc == SCORE_POS) begin
            sum = sum + 1;
        end else if (sc == SCORE_NEG) begin
            sum = sum - 1;
        end
        if (sum > SUM_CAP) begin
            sum = SUM_CAP;
        end
        if (sum > int'(best_total)) begin
            best_total = sum[12:0];
            best_lo    = seg_start;
            best_hi    = j[11:0];
            run_sum    = sum[12:0];
        end else if (sum < 0) begin
            // drop the candidate, next one starts after this base
            run_sum   = '0;
            seg_start = (j < IDX_CAP) ? 12'(j + 1) : 12'(IDX_CAP);
        end else begin
            run_sum = sum[12:0];
        end
        if (j < IDX_CAP) begin
            pos_idx = pos_idx + 12'd1;
        end
        res = NO_TRIM;
        if (!last) begin
            return 1'b0;
        end
        if (cfg_cutoff == '0) begin
            // trimming off: whole read
            res.seg_first = '0;
            res.seg_last  = j[11:0];
            res.score     = '0;
            res.keep      = 1'b1;
        end else begin
            res.seg_first = best_lo;
            res.seg_last  = best_hi;
            res.score     = best_total;
            len = (best_hi >= best_lo) ? int'(best_hi) - int'(best_lo) + 1 : 1;
            res.keep = (len >= int'(cfg_min_len));
        end
        pos_idx    = '0;
        run_sum    = '0;
        best_total = '0;
        seg_start  = '0;
        best_lo    = '0;
        best_hi    = '0;
        return 1'b1;
    endfunction

    // Offer one base request, with random sender gaps ahead of it. A typed
    // result, where given, replaces the predicted one in the queue.
    task automatic push_base(input logic [7:0] q, input logic last,
                             input bit use_typed, input t_trim typed_res);
        t_trim res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_quality_char <= q;
        i_last_base    <= last;
        do @(posedge i_clk); while (!o_in_ready);
        if (score_base(q, last, res)) begin
            expected_trims.push_back(use_typed ? typed_res : res);
        end
    endtask

    // Register write: only once the block has gone quiet.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] data);
        i_in_valid <= 1'b0;
        while (expected_trims.size() != 0) @(posedge i_clk);
        // a base with no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_QUALITY_OFFSET: cfg_offset  = data[OFFSET_W-1:0];
            CFG_PHRED_CUTOFF:   cfg_cutoff  = data[CUTOFF_W-1:0];
            CFG_MINIMUM_LENGTH: cfg_min_len = data[MINLEN_W-1:0];
            default: ;
        endcase
    endtask

    // Quality byte near the current threshold, pushed up inside the good
    // window and down outside it; some bytes are fully random.
    function automatic logic [7:0] pick_quality(input int bias);
        int v;
        if ($urandom_range(99) < 15) begin
            return 8'($urandom_range(255));
        end
        v = int'(cfg_offset) + int'(cfg_cutoff) + bias + int'($urandom_range(6)) - 3;
        if (v < 0) begin
            v = 0;
        end else if (v > 255) begin
            v = 255;
        end
        return v[7:0];
    endfunction

    // Random reads. Stops after n bases even in the middle of a read, so the
    // next register write can land mid-read; close_read just ends an open read.
    task automatic run_reads(input int n, input bit close_read);
        int done;
        done = 0;
        while ((!close_read && done < n) || (close_read && read_pos != read_len)) begin
            if (read_pos == read_len) begin
                read_len = ($urandom_range(9) == 0) ? $urandom_range(41, 160)
                                                    : $urandom_range(1, 40);
                read_pos = 0;
                win_lo   = $urandom_range(0, read_len - 1);
                win_hi   = $urandom_range(win_lo, read_len - 1);
            end
            push_base(pick_quality((read_pos >= win_lo && read_pos <= win_hi) ? 2 : -2),
                      read_pos == read_len - 1, 1'b0, NO_TRIM);
            read_pos++;
            done++;
        end
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready     <= 1'b0;
            drain_hold_left <= 0;
        end else if (drain_hold_go) begin
            i_out_ready     <= 1'b0;
            drain_hold_left <= HOLD_CYCLES;
        end else if (drain_hold_left != 0) begin
            i_out_ready     <= 1'b0;
            drain_hold_left <= drain_hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= drain_stall_pct);
        end
    end

    // Check every accepted result against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_trim got;
        t_trim want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_trim_start, o_trim_end, o_best_sum, o_keep_read};
            if (expected_trims.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: start %0d end %0d sum %0d keep %0d",
                             got.seg_first, got.seg_last, got.score, got.keep);
                end
            end else begin
                want = expected_trims.pop_front();
                if (got.seg_first != want.seg_first || got.seg_last != want.seg_last ||
                    got.score != want.score || got.keep != want.keep) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected start %0d end %0d sum %0d keep %0d",
                                 want.seg_first, want.seg_last, want.score, want.keep);
                        $display("          actual   start %0d end %0d sum %0d keep %0d",
                                 got.seg_first, got.seg_last, got.score, got.keep);
                    end
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no gaps or stalls
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                write_reg(DIRECTED[r].reg_sel, DIRECTED[r].value);
            end else begin
                push_base(DIRECTED[r].value[7:0], DIRECTED[r].last,
                          DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        // random reads under each setting
        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_QUALITY_OFFSET, 13'(PHASE_SET[p].offset));
            write_reg(CFG_PHRED_CUTOFF, 13'(PHASE_SET[p].cutoff));
            write_reg(CFG_MINIMUM_LENGTH, PHASE_SET[p].min_len);
            send_idle_pct   = int'(PHASE_SET[p].idle_pct);
            drain_stall_pct = int'(PHASE_SET[p].stall_pct);
            run_reads(int'(PHASE_SET[p].bases), 1'b0);
        end
        run_reads(0, 1'b1);

        // Back-pressure: result side holds off while one-base reads keep
        // coming, so the output fills and the input stalls.
        write_reg(CFG_QUALITY_OFFSET, 13'(SANGER_OFFSET));
        write_reg(CFG_PHRED_CUTOFF, 13'd20);
        write_reg(CFG_MINIMUM_LENGTH, 13'd1);
        send_idle_pct   = 0;
        drain_stall_pct = 0;
        drain_hold_go <= 1'b1;
        @(posedge i_clk);
        drain_hold_go <= 1'b0;
        repeat (24) begin
            push_base(8'($urandom_range(255)), 1'b1, 1'b0, NO_TRIM);
        end

        i_in_valid <= 1'b0;
        while (expected_trims.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_trims.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 8);
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/qmst_pkg.sv
rtl/qmst_score.sv
rtl/qmst_kadane.sv
rtl/quality_max_segment_trimmer.sv
bench/tb_quality_max_segment_trimmer.sv
